@@ rtl/ssm_pkg.sv @@
`default_nettype none

package ssm_pkg;

    localparam int unsigned QueueDepth   = 2;
    localparam int unsigned DigitCount   = 4;
    localparam int unsigned SegWidth     = 7;
    localparam int unsigned BitsPerDigit = 8;
    localparam int unsigned BitCntW      = 3;
    localparam logic [15:0] MaxNumber    = 16'd9999;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } ssm_front_state_t;

    typedef struct packed {
        logic                                  is_load;
        logic [DigitCount-1:0][SegWidth-1:0]   patterns;
    } ssm_entry_t;

    function automatic logic [SegWidth-1:0] digit_glyph(input logic [3:0] digit);
        logic [SegWidth-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssm_fifo.sv @@
`default_nettype none

module ssm_fifo
    import ssm_pkg::*;
#(
    parameter int unsigned Depth = QueueDepth
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire ssm_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output ssm_entry_t      pop_data,
    output logic            empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    ssm_entry_t            mem_reg [Depth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;

    assign full     = (cnt_reg == CntW'(Depth));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssm_front.sv @@
`default_nettype none

module ssm_front
    import ssm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] number,
    output logic             push,
    output ssm_entry_t       push_entry,
    input  wire logic        full
);

    ssm_front_state_t state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [15:0]      bin_reg;
    logic [15:0]      bcd_reg;
    logic [15:0]      bin_v;
    logic [15:0]      bcd_v;
    logic [15:0]      sat_number;
    logic             load_accept;

    assign sat_number  = (number > MaxNumber) ? MaxNumber : number;
    assign load_accept = (state_reg == FE_IDLE) && in_valid && !full && !command;

    // double dabble, four bits per cycle
    always_comb
    begin
        bcd_v = bcd_reg;
        bin_v = bin_reg;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < 4; d++)
            begin
                if (bcd_v[d*4 +: 4] >= 4'd5)
                begin
                    bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
                end
            end
            {bcd_v, bin_v} = {bcd_v, bin_v} << 1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (load_accept)
                begin
                    state_next = FE_CONV;
                end
            end
            FE_CONV:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                if (!full)
                begin
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                in_ready = !full;
                push     = in_valid && !full && command;
            end
            FE_PUSH:
            begin
                push = !full;
            end
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
        push_entry.is_load     = (state_reg == FE_PUSH);
        push_entry.patterns[0] = digit_glyph(bcd_reg[15:12]);
        push_entry.patterns[1] = digit_glyph(bcd_reg[11:8]);
        push_entry.patterns[2] = digit_glyph(bcd_reg[7:4]);
        push_entry.patterns[3] = digit_glyph(bcd_reg[3:0]);
    end

    assign step_next = (state_reg == FE_CONV) ? step_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            bin_reg <= sat_number;
            bcd_reg <= '0;
        end
        else if (state_reg == FE_CONV)
        begin
            bin_reg <= bin_v;
            bcd_reg <= bcd_v;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssm_back.sv @@
`default_nettype none

module ssm_back
    import ssm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ssm_entry_t  entry,
    input  wire logic        empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             serial_bit,
    output logic             is_last,
    output logic [3:0]       digit_enables,
    output logic [1:0]       shown_position
);

    logic                                busy_reg, busy_next;
    logic [BitCntW-1:0]                  bit_cnt_reg, bit_cnt_next;
    logic [BitsPerDigit-1:0]             shift_reg, shift_next;
    logic [1:0]                          pos_reg, pos_next;
    logic [3:0]                          enable_reg, enable_next;
    logic [DigitCount-1:0][SegWidth-1:0] pat_reg, pat_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                serial_bit_reg, serial_bit_next;
    logic                                is_last_reg, is_last_next;
    logic [3:0]                          digit_enables_reg, digit_enables_next;
    logic [1:0]                          shown_position_reg, shown_position_next;
    logic                                out_free;
    logic                                emit;
    logic                                last_bit;
    logic [3:0]                          new_en;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign last_bit = (bit_cnt_reg == BitCntW'(BitsPerDigit - 1));
    assign new_en   = ~(4'b0001 << pos_reg);
    assign pop      = !empty && (!busy_reg || (emit && last_bit));

    always_comb
    begin
        busy_next           = busy_reg;
        bit_cnt_next        = bit_cnt_reg;
        shift_next          = shift_reg;
        pos_next            = pos_reg;
        enable_next         = enable_reg;
        pat_next            = pat_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        serial_bit_next     = serial_bit_reg;
        is_last_next        = is_last_reg;
        digit_enables_next  = digit_enables_reg;
        shown_position_next = shown_position_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            serial_bit_next     = shift_reg[BitsPerDigit-1];
            is_last_next        = last_bit;
            digit_enables_next  = last_bit ? new_en : enable_reg;
            shown_position_next = pos_reg;
            shift_next          = shift_reg << 1;
            bit_cnt_next        = bit_cnt_reg + 1'b1;
            if (last_bit)
            begin
                busy_next   = 1'b0;
                enable_next = new_en;
                pos_next    = pos_reg + 1'b1;
            end
        end
        if (pop)
        begin
            if (entry.is_load)
            begin
                pat_next = entry.patterns;
            end
            else
            begin
                busy_next    = 1'b1;
                bit_cnt_next = '0;
                shift_next   = {1'b0, pat_reg[pos_next]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            pos_reg       <= '0;
            enable_reg    <= 4'hF;
            pat_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            bit_cnt_reg   <= bit_cnt_next;
            pos_reg       <= pos_next;
            enable_reg    <= enable_next;
            pat_reg       <= pat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg          <= shift_next;
        serial_bit_reg     <= serial_bit_next;
        is_last_reg        <= is_last_next;
        digit_enables_reg  <= digit_enables_next;
        shown_position_reg <= shown_position_next;
    end

    assign out_valid      = out_valid_reg;
    assign serial_bit     = serial_bit_reg;
    assign is_last        = is_last_reg;
    assign digit_enables  = digit_enables_reg;
    assign shown_position = shown_position_reg;

    a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (bit_cnt_reg == '0))
        else $error("bit counter not cleared while idle");

    a_first_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && bit_cnt_reg == '0) |=> !serial_bit_reg)
        else $error("first shifted bit not zero");

    a_last_one_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_last_reg) |->
            ($countones(digit_enables_reg) == 3 && !digit_enables_reg[shown_position_reg]))
        else $error("latch transfer enables do not select shown position");

endmodule

`default_nettype wire

@@ rtl/seven_segment_mux_serializer_core.sv @@
// Load: no result; digits split in FE_CONV, queued in FE_PUSH, input reopens in FE_IDLE.
// Refresh: queue, shifter, output register; one bit per cycle unless out_ready stalls.
// Each refresh is eight bits from the shifter; the queue can take new commands meanwhile.
// A 2-entry queue separates input decode from the shifter.
// Reset (async, active low): blank patterns, position 0, all enables high.
`default_nettype none

module seven_segment_mux_serializer_core
    import ssm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             serial_bit,
    output logic             is_last,
    output logic [3:0]       digit_enables,
    output logic [1:0]       shown_position
);

    ssm_entry_t push_entry;
    ssm_entry_t pop_entry;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    ssm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .number     (number),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    ssm_fifo #(
        .Depth (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_entry),
        .empty     (empty)
    );

    ssm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .entry          (pop_entry),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .serial_bit     (serial_bit),
        .is_last        (is_last),
        .digit_enables  (digit_enables),
        .shown_position (shown_position)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam int unsigned SHOW_LIMIT     = 9999;
    localparam int unsigned RANDOM_ITEMS   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 20;

    // segment glyphs for digits 9 down to 0, bit 0 = segment a
    localparam logic [9:0][6:0] GLYPH = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct {
        logic        cmd;
        logic [15:0] value;
        bit          drain_first;
        bit          calm;
    } display_cmd_t;

    typedef struct {
        logic       serial_bit;
        logic       is_last;
        logic [3:0] digit_enables;
        logic [1:0] shown_position;
    } serial_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_LOAD;
    logic [15:0] number = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        serial_bit;
    logic        is_last;
    logic [3:0]  digit_enables;
    logic [1:0]  shown_position;

    display_cmd_t cmd_backlog[$];
    serial_beat_t bit_stream_expect[$];

    // predicted display state
    logic [6:0] glyph_at [4] = '{7'h00, 7'h00, 7'h00, 7'h00};
    logic [1:0] scan_pos = 2'd0;
    logic [3:0] scan_enables = 4'hF;

    int unsigned err_count = 0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    bit          calm_now = 1'b0;

    seven_segment_mux_serializer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .number         (number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .serial_bit     (serial_bit),
        .is_last        (is_last),
        .digit_enables  (digit_enables),
        .shown_position (shown_position)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    function automatic logic [15:0] pick_number();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(SHOW_LIMIT));
        else if (r < 75)
            return 16'($urandom_range(10010, 9990));
        else
            return 16'($urandom_range(65535));
    endfunction

    task automatic predict_display(input logic cmd, input logic [15:0] value);
        int unsigned  n;
        logic [7:0]   pat;
        logic [3:0]   new_en;
        serial_beat_t beat;
        if (cmd == CMD_LOAD)
        begin
            n = 32'(value);
            if (n > SHOW_LIMIT)
                n = SHOW_LIMIT;
            glyph_at[0] = GLYPH[n / 1000];
            glyph_at[1] = GLYPH[(n / 100) % 10];
            glyph_at[2] = GLYPH[(n / 10) % 10];
            glyph_at[3] = GLYPH[n % 10];
        end
        else
        begin
            pat    = {1'b0, glyph_at[scan_pos]};
            new_en = 4'hF & ~(4'b0001 << scan_pos);
            for (int b = 0; b < 8; b++)
            begin
                beat.serial_bit     = pat[7 - b];
                beat.is_last        = (b == 7);
                beat.digit_enables  = (b == 7) ? new_en : scan_enables;
                beat.shown_position = scan_pos;
                bit_stream_expect.push_back(beat);
            end
            scan_enables = new_en;
            scan_pos     = scan_pos + 2'd1;
        end
    endtask

    task automatic queue_cmd(input logic cmd, input logic [15:0] value,
                             input bit drain_first, input bit calm);
        display_cmd_t c;
        c.cmd         = cmd;
        c.value       = value;
        c.drain_first = drain_first;
        c.calm        = calm;
        cmd_backlog.push_back(c);
    endtask

    // input side
    always @(posedge clk)
    begin : drive_cmds
        logic next_valid;
        next_valid = in_valid && !in_ready;
        if (rst_n && !next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (cmd_backlog.size() > 0 &&
                     (!cmd_backlog[0].drain_first ||
                      (bit_stream_expect.size() == 0 && !(in_valid && in_ready))))
            begin
                command    <= cmd_backlog[0].cmd;
                number     <= cmd_backlog[0].value;
                calm_now   = cmd_backlog[0].calm;
                send_gap   = pick_gap(cmd_backlog[0].calm);
                void'(cmd_backlog.pop_front());
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // output side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                hold_left = pick_gap(calm_now);
        end
    end

    always @(posedge clk)
    begin : watch_ports
        serial_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_display(command, number);
            if (out_valid && out_ready)
            begin
                if (bit_stream_expect.size() == 0)
                    report_mismatch("output transfer with nothing expected");
                else
                begin
                    want = bit_stream_expect.pop_front();
                    if (serial_bit !== want.serial_bit)
                        report_mismatch($sformatf("serial_bit %b, expected %b",
                                                  serial_bit, want.serial_bit));
                    if (is_last !== want.is_last)
                        report_mismatch($sformatf("is_last %b, expected %b",
                                                  is_last, want.is_last));
                    if (digit_enables !== want.digit_enables)
                        report_mismatch($sformatf("digit_enables %h, expected %h",
                                                  digit_enables, want.digit_enables));
                    if (shown_position !== want.shown_position)
                        report_mismatch($sformatf("shown_position %0d, expected %0d",
                                                  shown_position, want.shown_position));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned queued;
        int unsigned ticks;
        bit          calm;
        bit          drain;

        // blank display, enables still at reset value on the first tick
        for (int k = 0; k < 4; k++)
            queue_cmd(CMD_TICK, 16'hFFFF, 1'b0, 1'b0);
        queue_cmd(CMD_LOAD, 16'd0, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            queue_cmd(CMD_TICK, 16'd0, 1'b0, 1'b0);
        queue_cmd(CMD_LOAD, 16'd1234, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            queue_cmd(CMD_TICK, 16'h5A5A, 1'b0, 1'b0);
        queue_cmd(CMD_LOAD, 16'd5678, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            queue_cmd(CMD_TICK, 16'hA5A5, 1'b0, 1'b0);
        // saturation
        queue_cmd(CMD_LOAD, 16'hFFFF, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            queue_cmd(CMD_TICK, 16'd0, 1'b0, 1'b0);
        queue_cmd(CMD_LOAD, 16'd10000, 1'b0, 1'b0);

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            calm  = ($urandom_range(4) == 0);
            drain = (queued == 0) || ($urandom_range(24) == 0);
            if ($urandom_range(9) == 0)
            begin
                for (int k = $urandom_range(4, 1); k > 0; k--)
                begin
                    queue_cmd(1'($urandom_range(1)), 16'($urandom_range(65535)),
                              drain, calm);
                    drain = 1'b0;
                    queued++;
                end
            end
            else
            begin
                queue_cmd(CMD_LOAD, pick_number(), drain, calm);
                ticks = $urandom_range(8, 1);
                for (int k = 0; k < ticks; k++)
                    queue_cmd(CMD_TICK, 16'($urandom_range(65535)), 1'b0, calm);
                queued += ticks + 1;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || in_valid || bit_stream_expect.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
